/* rtl/core/cfba_pkg.sv */
// ----------------------------------------------------------------------------
// cfba_pkg: chunked fixed block allocator shared types
// Request/result structs, sequencer states and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

  localparam int unsigned MaxChunks = 16;
  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned ChunkW    = $clog2(MaxChunks);
  localparam int unsigned BlockW    = $clog2(MaxBlocks);
  localparam int unsigned ActiveW   = ChunkW + 1;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoChunks  = 2'd1;
  localparam logic [1:0] StatusBadFree   = 2'd2;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ChunkW-1:0] free_chunk_id;
    logic [BlockW-1:0] free_block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ChunkW-1:0] grant_chunk_id;
    logic [BlockW-1:0] grant_block_index;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StAllocCheck,
    StAllocScan,
    StAllocInit,
    StAllocPop,
    StAllocRead,
    StFreeScan,
    StFreeTail
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/chunked_fixed_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// chunked_fixed_block_allocator_unit: fixed-size block allocator over chunks
// Per request: allocate takes the cached slot on a hit, else scans the active
// chunks for one with room, ends with no chunks when all are in use, or sets up
// a new chunk (one link write per cycle). Free scans for the owner slot, with a
// tail step when that chunk empties; a bad index or no owner returns bad free.
// done_o pulses in the first idle cycle and is never held off. Reset clears the
// slot map, counters and cached slot; link memory and per-chunk head/count are not
// cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_fixed_block_allocator_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cfba_pkg::req_t    req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output cfba_pkg::rsp_t         rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned CW = cfba_pkg::ChunkW;
  localparam int unsigned BW = cfba_pkg::BlockW;
  localparam int unsigned AW = cfba_pkg::ActiveW;
  localparam int unsigned NC = cfba_pkg::MaxChunks;

  cfba_pkg::state_e state_q, state_d;

  logic [BW-1:0] bpc_q;
  logic [CW-1:0] s2c_q [NC];
  logic [BW-1:0] head_q [NC];
  logic [BW-1:0] cnt_q [NC];
  logic [AW-1:0] active_q;
  logic [CW-1:0] alloc_slot_q;
  logic          alloc_valid_q;

  cfba_pkg::req_t req_q;
  logic [AW-1:0]  scan_q;
  logic [BW-1:0]  link_q;
  logic [CW-1:0]  chunk_q;
  logic [CW-1:0]  slot_q;
  logic [BW-1:0]  blk_q;
  logic           done_q;
  cfba_pkg::rsp_t rsp_q;

  logic [BW-1:0] link_mem [NC*cfba_pkg::MaxBlocks];
  logic [BW-1:0] rdata_q;
  logic          mem_we;
  logic [CW+BW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;

  logic [BW-1:0] n_blk;
  logic [CW-1:0] c_alloc, c_scan, c_act, c_last, c_prev;
  logic [AW-1:0] last;
  logic          hit, scan_in, scan_match;
  logic          cfg_wr;

  assign n_blk   = (bpc_q == '0) ? BW'(1) : bpc_q;
  assign c_alloc = s2c_q[alloc_slot_q];
  assign c_scan  = s2c_q[scan_q[CW-1:0]];
  assign c_act   = s2c_q[active_q[CW-1:0]];
  assign last    = active_q - AW'(1);
  assign c_last  = s2c_q[last[CW-1:0]];
  assign c_prev  = s2c_q[CW'(last - AW'(1))];
  assign hit     = alloc_valid_q && ({1'b0, alloc_slot_q} < active_q) &&
                   (cnt_q[c_alloc] != '0);
  assign scan_in = scan_q < active_q;
  assign scan_match = (c_scan == req_q.free_chunk_id);

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, bpc_q} : 32'd0;

  assign busy_o = (state_q != cfba_pkg::StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfba_pkg::StIdle: begin
        if (start_i) begin
          state_d = (req_i.kind == cfba_pkg::KindFree) ? cfba_pkg::StFreeScan
                                                       : cfba_pkg::StAllocCheck;
        end
      end
      cfba_pkg::StAllocCheck: begin
        state_d = hit ? cfba_pkg::StAllocPop : cfba_pkg::StAllocScan;
      end
      cfba_pkg::StAllocScan: begin
        if (scan_in) begin
          if (cnt_q[c_scan] != '0) state_d = cfba_pkg::StAllocPop;
        end else if (active_q >= AW'(NC)) begin
          state_d = cfba_pkg::StIdle;
        end else begin
          state_d = cfba_pkg::StAllocInit;
        end
      end
      cfba_pkg::StAllocInit: begin
        if (link_q == n_blk - BW'(1)) state_d = cfba_pkg::StAllocPop;
      end
      cfba_pkg::StAllocPop:  state_d = cfba_pkg::StAllocRead;
      cfba_pkg::StAllocRead: state_d = cfba_pkg::StIdle;
      cfba_pkg::StFreeScan: begin
        if (!scan_in || req_q.free_block_index >= n_blk) begin
          state_d = cfba_pkg::StIdle;
        end else if (scan_match) begin
          state_d = (cnt_q[c_scan] + BW'(1) == n_blk) ? cfba_pkg::StFreeTail
                                                       : cfba_pkg::StIdle;
        end
      end
      cfba_pkg::StFreeTail: state_d = cfba_pkg::StIdle;
      default: state_d = cfba_pkg::StIdle;
    endcase
  end

  // link memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {chunk_q, link_q};
    mem_wdata = link_q + BW'(1);
    if (state_q == cfba_pkg::StAllocInit) begin
      mem_we = 1'b1;
    end else if (state_q == cfba_pkg::StFreeScan && scan_in && scan_match &&
                 req_q.free_block_index < n_blk) begin
      mem_we    = 1'b1;
      mem_waddr = {c_scan, req_q.free_block_index};
      mem_wdata = head_q[c_scan];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (state_q == cfba_pkg::StAllocPop) begin
      rdata_q <= link_mem[{c_alloc, head_q[c_alloc]}];
    end
  end

  // per-chunk head and count, no reset (undefined until activated)
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cfba_pkg::StAllocScan: begin
        if (!scan_in && active_q < AW'(NC)) begin
          head_q[c_act] <= '0;
          cnt_q[c_act]  <= n_blk;
        end
      end
      cfba_pkg::StAllocRead: begin
        head_q[chunk_q] <= rdata_q;
        cnt_q[chunk_q]  <= cnt_q[chunk_q] - BW'(1);
      end
      cfba_pkg::StFreeScan: begin
        if (scan_in && scan_match && req_q.free_block_index < n_blk) begin
          head_q[c_scan] <= req_q.free_block_index;
          cnt_q[c_scan]  <= cnt_q[c_scan] + BW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cfba_pkg::StIdle && start_i) req_q <= req_i;
    if (state_q == cfba_pkg::StAllocPop) begin
      chunk_q <= c_alloc;
      blk_q   <= head_q[c_alloc];
    end
    if (state_q == cfba_pkg::StAllocScan) chunk_q <= c_act;
    if (state_q == cfba_pkg::StFreeScan) slot_q <= scan_q[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= cfba_pkg::StIdle;
      bpc_q         <= 8'd255;
      active_q      <= '0;
      alloc_slot_q  <= '0;
      alloc_valid_q <= 1'b0;
      scan_q        <= '0;
      link_q        <= '0;
      done_q        <= 1'b0;
      rsp_q         <= '0;
      for (int i = 0; i < NC; i++) s2c_q[i] <= CW'(i);
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_wr) bpc_q <= pwdata[7:0];
      unique case (state_q)
        cfba_pkg::StIdle: begin
          scan_q <= '0;
          link_q <= '0;
        end
        cfba_pkg::StAllocCheck: begin
          if (!hit) alloc_valid_q <= 1'b0;
        end
        cfba_pkg::StAllocScan: begin
          if (scan_in) begin
            if (cnt_q[c_scan] != '0) begin
              alloc_slot_q  <= scan_q[CW-1:0];
              alloc_valid_q <= 1'b1;
            end else begin
              scan_q <= scan_q + AW'(1);
            end
          end else if (active_q >= AW'(NC)) begin
            done_q <= 1'b1;
            rsp_q  <= '{status: cfba_pkg::StatusNoChunks, default: '0};
          end
        end
        cfba_pkg::StAllocInit: begin
          link_q <= link_q + BW'(1);
          if (link_q == n_blk - BW'(1)) begin
            alloc_slot_q  <= active_q[CW-1:0];
            alloc_valid_q <= 1'b1;
            active_q      <= active_q + AW'(1);
          end
        end
        cfba_pkg::StAllocRead: begin
          done_q <= 1'b1;
          rsp_q  <= '{status: cfba_pkg::StatusOk, grant_chunk_id: chunk_q,
                      grant_block_index: blk_q};
        end
        cfba_pkg::StFreeScan: begin
          if (!scan_in || req_q.free_block_index >= n_blk) begin
            done_q <= 1'b1;
            rsp_q  <= '{status: cfba_pkg::StatusBadFree, default: '0};
          end else if (scan_match) begin
            if (cnt_q[c_scan] + BW'(1) != n_blk) begin
              done_q <= 1'b1;
              rsp_q  <= '{status: cfba_pkg::StatusOk, default: '0};
            end
          end else begin
            scan_q <= scan_q + AW'(1);
          end
        end
        cfba_pkg::StFreeTail: begin
          done_q <= 1'b1;
          rsp_q  <= '{status: cfba_pkg::StatusOk, default: '0};
          if ({1'b0, slot_q} == last) begin
            // freed chunk is the tail: drop it if the one before is empty too
            if (active_q > AW'(1) && cnt_q[c_prev] == n_blk) begin
              active_q      <= last;
              alloc_slot_q  <= '0;
              alloc_valid_q <= 1'b1;
            end
          end else if (cnt_q[c_last] == n_blk) begin
            active_q      <= last;
            alloc_slot_q  <= slot_q;
            alloc_valid_q <= 1'b1;
          end else begin
            // move the empty chunk to the tail slot
            s2c_q[slot_q]         <= c_last;
            s2c_q[last[CW-1:0]]   <= s2c_q[slot_q];
            alloc_slot_q          <= last[CW-1:0];
            alloc_valid_q         <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
